// File: rtl/sapc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapc_pkg
// shared types and constants of the set-associative path cache
// ----------------------------------------------------------------------------
package sapc_pkg;

  localparam int NODE_W = 16;
  localparam int KEY_W  = 32;
  localparam int WORD_W = 32;
  localparam int MULT_W = 16;
  localparam int HASH_W = 33;   // start*mult + end*mult never exceeds 33 bits
  localparam int CFG_ADDR_W = 8;
  localparam int IDX_OUT_W  = 4;
  localparam int LEN_OUT_W  = 5;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MULT_START = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MULT_END   = 8'd1;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // request into the remainder unit
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] value;
  } sapc_mod_req_t;

endpackage

// File: rtl/sapc_modu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapc_modu
// remainder of the hash by the bucket count, by folding the high part back in
// ----------------------------------------------------------------------------
module sapc_modu #(
  parameter int BUCKETS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sapc_pkg::sapc_mod_req_t    req_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] rem_o
);
  import sapc_pkg::*;

  localparam int SET_W = $clog2(BUCKETS);
  localparam int HI_W  = HASH_W - SET_W;
  // 2^SET_W mod BUCKETS, zero for a power of two
  localparam logic [SET_W-1:0] FOLD_C = SET_W'((1 << SET_W) - BUCKETS);

  logic [SET_W-1:0]  rem_q;
  logic [HASH_W-1:0] val_q;
  logic              busy_q;
  logic              done_q;
  logic [HI_W-1:0]   hi;
  logic [SET_W-1:0]  lo;
  logic [HASH_W-1:0] folded;
  logic [SET_W:0]    lo_ext;
  logic [SET_W:0]    reduced;
  logic [SET_W-1:0]  final_rem;

  assign hi        = val_q[HASH_W-1:SET_W];
  assign lo        = val_q[SET_W-1:0];
  // hi*2^SET_W + lo folds to hi*FOLD_C + lo, never larger than the value
  assign folded    = HASH_W'(hi) * HASH_W'(FOLD_C) + HASH_W'(lo);
  assign lo_ext    = {1'b0, lo};
  assign reduced   = lo_ext - (SET_W+1)'(BUCKETS);
  // lo is below 2*BUCKETS, one subtract finishes it
  assign final_rem = (lo_ext >= (SET_W+1)'(BUCKETS)) ? reduced[SET_W-1:0] : lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (hi == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      val_q <= req_i.value;
    end else if (busy_q) begin
      if (hi != '0) val_q <= folded;
      else rem_q <= final_rem;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("remainder unit did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("remainder done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_q |-> ({1'b0, rem_q} < (SET_W+1)'(BUCKETS)))
    else $error("remainder out of range");

endmodule

// File: rtl/set_assoc_path_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_path_cache
// set-associative cache of paths keyed by start and end node, with aging
// ----------------------------------------------------------------------------
// a lookup or a first insert word is multiplied, hashed and reduced in the folding
//   remainder unit, which folds until the high part is zero; each way scanned is then
//   read and updated, with an eviction step when no way is free or matches
// a hit sends each beat through path read, load and result, held until taken; a later
//   insert word goes to the store step; one item in flight, ready only when idle
// config always taken; a reset clears every way's tag word, no item taken meanwhile
module set_assoc_path_cache #(
  parameter int BUCKETS  = 256,
  parameter int WAYS     = 4,
  parameter int PATH_LEN = 16,
  parameter int AGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sapc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [sapc_pkg::MULT_W-1:0]       cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // start_node, end_node, path_word
  input  logic [1:0]  s_axis_tuser,   // op, first_word
  input  logic        s_axis_tlast,   // last_word
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_word, word_index, path_length, zero pad
  output logic [1:0]  m_axis_tuser,   // hit, evicted
  output logic        m_axis_tlast    // last
);
  import sapc_pkg::*;

  localparam int SET_W  = $clog2(BUCKETS);
  localparam int NWAYS  = BUCKETS * WAYS;
  localparam int WA_W   = $clog2(NWAYS);
  localparam int WC_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int POS_W  = $clog2(PATH_LEN + 1);
  localparam int PA_W   = $clog2(NWAYS * PATH_LEN);

  typedef struct packed {
    logic                valid;
    logic [AGE_BITS-1:0] age;
    logic [KEY_W-1:0]    key;
  } meta_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_MOD, S_RD, S_EV, S_EVICT, S_STORE, S_PRD, S_PLD, S_RES
  } state_e;

  state_e state_q;

  // configuration
  logic [MULT_W-1:0] mult_start_q, mult_end_q;

  // latched beat
  logic              op_q, last_w_q;
  logic [KEY_W-1:0]  key_q;
  logic [WORD_W-1:0] word_q;
  logic [31:0]       prod_q;
  logic [31:0]       prod_end;

  // scan state
  logic [SET_W-1:0]    set_q;
  logic [WC_W-1:0]     way_q;
  logic [WA_W-1:0]     way_addr;
  logic [WA_W-1:0]     clr_cnt_q;
  logic                found_q;
  logic [WA_W-1:0]     hw_q;
  logic [POS_W-1:0]    hlen_q;
  logic [POS_W-1:0]    k_q;
  logic                have_best_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [WA_W-1:0]     best_q;

  // open insert
  logic [WA_W-1:0]  target_q;
  logic [POS_W-1:0] pos_q;
  logic             discard_q, evicted_q, started_q;

  // result register
  logic              mvalid_q, o_hit_q, o_ev_q, o_last_q;
  logic [WORD_W-1:0] o_word_q;
  logic [POS_W-1:0]  o_idx_q, o_len_q;

  // memories
  meta_t             meta_mem [NWAYS];
  logic [POS_W-1:0]  len_mem  [NWAYS];
  logic [WORD_W-1:0] path_mem [NWAYS * PATH_LEN];
  meta_t             meta_rd_q;
  logic [POS_W-1:0]  len_rd_q;
  logic [WORD_W-1:0] path_rd_q;

  logic              meta_we, len_we, path_we;
  logic [WA_W-1:0]   meta_wa, len_wa;
  meta_t             meta_wd;
  logic [POS_W-1:0]  len_wd;
  logic [PA_W-1:0]   path_wa, path_ra;

  // remainder unit
  sapc_mod_req_t     mod_req;
  logic              mod_done;
  logic [SET_W-1:0]  mod_rem;

  // per-way evaluation
  meta_t               m;
  logic                key_eq, last_way, can_store;
  logic [AGE_BITS-1:0] aged;
  logic [POS_W-1:0]    new_pos;

  assign m         = meta_rd_q;
  assign key_eq    = (m.key == key_q);
  assign aged      = (&m.age) ? m.age : m.age + 1'b1;
  assign last_way  = (way_q == WC_W'(WAYS - 1));
  assign way_addr  = WA_W'(WA_W'(set_q) * WA_W'(WAYS) + WA_W'(way_q));
  assign prod_end  = key_q[NODE_W-1:0] * mult_end_q;
  assign can_store = started_q && !discard_q && (pos_q < POS_W'(PATH_LEN));
  assign new_pos   = can_store ? pos_q + 1'b1 : pos_q;
  assign path_wa   = PA_W'(PA_W'(target_q) * PA_W'(PATH_LEN) + PA_W'(pos_q));
  assign path_ra   = PA_W'(PA_W'(hw_q) * PA_W'(PATH_LEN) + PA_W'(k_q));

  assign mod_req.start = (state_q == S_HASH);
  assign mod_req.value = HASH_W'(prod_q) + HASH_W'(prod_end);

  sapc_modu #(.BUCKETS(BUCKETS)) u_modu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // memory write steering
  always_comb begin
    meta_we = 1'b0;
    meta_wa = way_addr;
    meta_wd = '0;
    len_we  = 1'b0;
    len_wa  = way_addr;
    len_wd  = '0;
    path_we = 1'b0;
    case (state_q)
      S_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_cnt_q;
      end
      S_EV: begin
        if (op_q == OP_LOOKUP) begin
          meta_we = m.valid;
          meta_wd = m;
          meta_wd.age = (!found_q && key_eq) ? '0 : aged;
        end else if (!m.valid) begin
          // empty way: fill it
          meta_we = 1'b1;
          meta_wd = '{valid: 1'b1, age: '0, key: key_q};
          len_we  = 1'b1;
        end else begin
          meta_we = 1'b1;
          meta_wd = m;
          meta_wd.age = aged;
        end
      end
      S_EVICT: begin
        meta_we = 1'b1;
        meta_wa = best_q;
        meta_wd = '{valid: 1'b1, age: '0, key: key_q};
        len_we  = 1'b1;
        len_wa  = best_q;
      end
      S_STORE: begin
        path_we = can_store;
        len_we  = can_store;
        len_wa  = target_q;
        len_wd  = new_pos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[way_addr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_rd_q <= len_mem[way_addr];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[path_wa] <= word_q;
    path_rd_q <= path_mem[path_ra];
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_start_q <= MULT_W'(31);
      mult_end_q   <= MULT_W'(37);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MULT_START: mult_start_q <= cfg_data_i;
        CFG_MULT_END:   mult_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      target_q    <= '0;
      pos_q       <= '0;
      discard_q   <= 1'b0;
      evicted_q   <= 1'b0;
      started_q   <= 1'b0;
      mvalid_q    <= 1'b0;
      way_q       <= '0;
      found_q     <= 1'b0;
      have_best_q <= 1'b0;
      k_q         <= '0;
    end else begin
      case (state_q)
        // sweep every way's tag word to empty
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == WA_W'(NWAYS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q     <= s_axis_tuser[0];
            last_w_q <= s_axis_tlast;
            key_q    <= {s_axis_tdata[15:0], s_axis_tdata[31:16]};
            word_q   <= s_axis_tdata[63:32];
            prod_q   <= s_axis_tdata[15:0] * mult_start_q;
            // a later insert word skips the set scan
            if (s_axis_tuser[0] == OP_INSERT && !s_axis_tuser[1]) state_q <= S_STORE;
            else state_q <= S_HASH;
          end
        end
        S_HASH: state_q <= S_MOD;
        S_MOD: begin
          if (mod_done) begin
            set_q       <= mod_rem;
            way_q       <= '0;
            found_q     <= 1'b0;
            have_best_q <= 1'b0;
            state_q     <= S_RD;
          end
        end
        S_RD: state_q <= S_EV;
        S_EV: begin
          if (op_q == OP_LOOKUP) begin
            if (m.valid && !found_q && key_eq) begin
              found_q <= 1'b1;
              hw_q    <= way_addr;
              hlen_q  <= len_rd_q;
            end
            if (last_way) begin
              if ((found_q || (m.valid && key_eq)) &&
                  ((found_q ? hlen_q : len_rd_q) != '0)) begin
                k_q     <= '0;
                state_q <= S_PRD;
              end else begin
                o_hit_q  <= found_q || (m.valid && key_eq);
                o_word_q <= '0;
                o_idx_q  <= '0;
                o_len_q  <= '0;
                o_ev_q   <= 1'b0;
                o_last_q <= 1'b1;
                mvalid_q <= 1'b1;
                state_q  <= S_RES;
              end
            end else begin
              way_q   <= way_q + 1'b1;
              state_q <= S_RD;
            end
          end else if (!m.valid) begin
            target_q  <= way_addr;
            discard_q <= 1'b0;
            evicted_q <= 1'b0;
            pos_q     <= '0;
            started_q <= 1'b1;
            state_q   <= S_STORE;
          end else if (key_eq) begin
            // key already cached: drop this insert
            target_q  <= way_addr;
            discard_q <= 1'b1;
            evicted_q <= 1'b0;
            pos_q     <= '0;
            started_q <= 1'b1;
            state_q   <= S_STORE;
          end else begin
            if (!have_best_q || aged > best_age_q) begin
              have_best_q <= 1'b1;
              best_age_q  <= aged;
              best_q      <= way_addr;
            end
            if (last_way) state_q <= S_EVICT;
            else begin
              way_q   <= way_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_EVICT: begin
          target_q  <= best_q;
          discard_q <= 1'b0;
          evicted_q <= 1'b1;
          pos_q     <= '0;
          started_q <= 1'b1;
          state_q   <= S_STORE;
        end
        S_STORE: begin
          pos_q <= new_pos;
          if (last_w_q) begin
            o_hit_q   <= 1'b0;
            o_word_q  <= '0;
            o_idx_q   <= '0;
            o_len_q   <= discard_q ? '0 : new_pos;
            o_ev_q    <= discard_q ? 1'b0 : evicted_q;
            o_last_q  <= 1'b1;
            mvalid_q  <= 1'b1;
            discard_q <= 1'b1;
            evicted_q <= 1'b0;
            pos_q     <= '0;
            state_q   <= S_RES;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_PRD: state_q <= S_PLD;
        S_PLD: begin
          o_hit_q  <= 1'b1;
          o_word_q <= path_rd_q;
          o_idx_q  <= k_q;
          o_len_q  <= hlen_q;
          o_ev_q   <= 1'b0;
          o_last_q <= (k_q + 1'b1 == hlen_q);
          mvalid_q <= 1'b1;
          state_q  <= S_RES;
        end
        S_RES: begin
          if (m_axis_tready) begin
            mvalid_q <= 1'b0;
            if (o_hit_q && !o_last_q) begin
              k_q     <= k_q + 1'b1;
              state_q <= S_PRD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {7'd0, LEN_OUT_W'(o_len_q), IDX_OUT_W'(o_idx_q), o_word_q};
  assign m_axis_tuser  = {o_ev_q, o_hit_q};
  assign m_axis_tlast  = o_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_CLR |-> !m_axis_tvalid)
    else $error("result during clearing pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid && o_hit_q && o_len_q != '0 |-> o_idx_q < o_len_q)
    else $error("word index beyond stored length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   started_q && !discard_q |-> pos_q <= POS_W'(PATH_LEN))
    else $error("insert position overran path");

endmodule

// File: verif/sapc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapc_checker
// predicts the path cache results from accepted beats and compares them
// ----------------------------------------------------------------------------
module sapc_checker #(
  parameter int BUCKETS  = 256,
  parameter int WAYS     = 4,
  parameter int PATH_LEN = 16,
  parameter int AGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [47:0] out_data_i,
  input  logic [1:0]  out_user_i,
  input  logic        out_last_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          hits_o
);
  import sapc_pkg::*;

  localparam int NW = BUCKETS * WAYS;
  localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

  typedef struct packed {
    logic        hit;
    logic [31:0] word;
    logic [3:0]  idx;
    logic [4:0]  len;
    logic        ev;
    logic        last;
  } beat_t;

  logic [15:0]         mult_start, mult_end;
  logic [31:0]         key_q   [NW];
  logic                valid_q [NW];
  logic [AGE_BITS-1:0] age_q   [NW];
  int                  len_q   [NW];
  logic [31:0]         path_q  [NW*PATH_LEN];
  int                  tgt, pos;
  logic                discard, evict;
  beat_t               expected_beats[$];

  function automatic int set_base(logic [15:0] sn, logic [15:0] en);
    longint h;
    h = longint'(sn) * mult_start + longint'(en) * mult_end;
    return int'(h % BUCKETS) * WAYS;
  endfunction

  function automatic void grow_age(int w);
    if (age_q[w] != AGE_TOP) age_q[w]++;
  endfunction

  function automatic void predict_beat(logic op, logic [15:0] sn, logic [15:0] en,
                                       logic [31:0] pw, logic first, logic lastw);
    logic [31:0] key;
    int base, hw, best, n;
    logic found;
    beat_t b;
    key = {sn, en};
    base = set_base(sn, en);
    if (op == OP_LOOKUP) begin
      found = 0;
      hw = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (!valid_q[base+i]) continue;
        if (!found && key_q[base+i] == key) begin
          found = 1;
          hw = base + i;
          age_q[hw] = '0;
        end else begin
          grow_age(base + i);
        end
      end
      b = '0;
      b.last = 1;
      if (found) begin
        hits_o++;
        b.hit = 1;
        n = len_q[hw];
        for (int i = 0; i < n; i++) begin
          b.word = path_q[hw*PATH_LEN+i];
          b.idx  = i[3:0];
          b.len  = n[4:0];
          b.last = (i + 1 == n);
          expected_beats.push_back(b);
        end
        if (n == 0) expected_beats.push_back(b);
      end else begin
        expected_beats.push_back(b);
      end
      return;
    end
    if (first) begin
      discard = 0;
      evict = 0;
      pos = 0;
      best = base;
      found = 0;
      for (int i = 0; i < WAYS && !found; i++) begin
        if (!valid_q[base+i]) begin
          tgt = base + i;
          valid_q[tgt] = 1;
          key_q[tgt] = key;
          age_q[tgt] = '0;
          len_q[tgt] = 0;
          found = 1;
        end else begin
          grow_age(base + i);
          if (key_q[base+i] == key) begin
            tgt = base + i;
            discard = 1;
            found = 1;
          end else if (i == 0 || age_q[base+i] > age_q[best]) begin
            best = base + i;
          end
        end
      end
      if (!found) begin
        tgt = best;
        evict = 1;
        key_q[tgt] = key;
        age_q[tgt] = '0;
        len_q[tgt] = 0;
      end
    end
    if (!discard && valid_q[tgt] && pos < PATH_LEN) begin
      path_q[tgt*PATH_LEN+pos] = pw;
      pos++;
      len_q[tgt] = pos;
    end
    if (lastw) begin
      b = '0;
      b.len = discard ? 5'd0 : pos[4:0];
      b.ev = discard ? 1'b0 : evict;
      b.last = 1;
      expected_beats.push_back(b);
      discard = 1;
      evict = 0;
      pos = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got, exp_b;
    if (!rst_ni) begin
      mult_start = 16'd31;
      mult_end   = 16'd37;
      for (int i = 0; i < NW; i++) begin
        valid_q[i] = 0;
        age_q[i]   = '0;
        len_q[i]   = 0;
        key_q[i]   = '0;
      end
      tgt = 0;
      pos = 0;
      discard = 0;
      evict = 0;
      errors_o = 0;
      results_o = 0;
      hits_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_addr_i == CFG_MULT_START) mult_start = cfg_data_i;
        else if (cfg_addr_i == CFG_MULT_END) mult_end = cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        predict_beat(in_user_i[0], in_data_i[15:0], in_data_i[31:16],
                     in_data_i[63:32], in_user_i[1], in_last_i);
      if (out_valid_i && out_ready_i) begin
        results_o = results_o + 1;
        got = {out_user_i[0], out_data_i[31:0], out_data_i[35:32], out_data_i[40:36],
               out_user_i[1], out_last_i};
        if (expected_beats.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp_b = expected_beats.pop_front();
          if (got !== exp_b) begin
            errors_o = errors_o + 1;
            if (errors_o <= 10)
              $display("mismatch: exp hit=%0d word=%h idx=%0d len=%0d ev=%0d last=%0d",
                       exp_b.hit, exp_b.word, exp_b.idx, exp_b.len, exp_b.ev,
                       exp_b.last, "  got hit=%0d word=%h idx=%0d len=%0d ev=%0d last=%0d",
                       got.hit, got.word, got.idx, got.len, got.ev, got.last);
          end
        end
      end
    end
  end

  assign pending_o = expected_beats.size();
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// directed and random lookups and inserts into the path cache under backpressure
// ----------------------------------------------------------------------------
module testbench;
  import sapc_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          errors, pending, results, hits;
  int          idle_pct = 38;   // stall rate on both sides, zeroed for a stretch
  int          hold_cycles = 0; // long receiver hold-off when nonzero

  // small key pool so inserts and lookups collide in the same sets
  logic [15:0] pool_start[8], pool_end[8];

  set_assoc_path_cache dut (.*);

  sapc_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_addr_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .in_user_i(s_axis_tuser), .in_last_i(s_axis_tlast),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .out_user_i(m_axis_tuser), .out_last_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending), .results_o(results), .hits_o(hits)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // generous limit: clearing pass plus worst-case items and stalls
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // one beat: op, key, word, first, last
  task automatic send_beat(logic op, logic [15:0] sn, logic [15:0] en,
                           logic [31:0] pw, logic first, logic lastw);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {pw, en, sn};
    s_axis_tuser  <= {first, op};
    s_axis_tlast  <= lastw;
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 0;
    // the block is busy for at least this cycle after a beat
    @(posedge clk_i);
  endtask

  task automatic send_path(logic [15:0] sn, logic [15:0] en, int n);
    for (int i = 0; i < n; i++)
      send_beat(OP_INSERT, sn, en, $urandom, i == 0, i == n - 1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] addr, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    int kind, k, n;
    rst_ni = 0;
    cfg_valid_i = 0; cfg_addr_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; s_axis_tlast = 0;
    for (int i = 0; i < 8; i++) begin
      pool_start[i] = 16'($urandom);
      pool_end[i]   = 16'($urandom);
    end
    pool_start[0] = 16'h0000; pool_end[0] = 16'h0000;
    pool_start[1] = 16'hFFFF; pool_end[1] = 16'hFFFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: stray words, extremes, full sets, eviction, dup, overflow
    send_beat(OP_INSERT, 16'h1, 16'h2, 32'hFFFF_FFFF, 1'b0, 1'b1);   // stray last word
    send_beat(OP_LOOKUP, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1);           // miss on empty cache
    drain();
    write_reg(CFG_MULT_START, 16'd0);
    write_reg(CFG_MULT_END, 16'd0);                            // everything in set 0
    for (int i = 0; i < 5; i++) send_path(16'(16'hFFFF - i), i[15:0], 1 + i);
    send_path(16'hFFFF, 16'h0, 3);                             // duplicate or re-insert
    send_path(16'hABCD, 16'h1234, 20);                         // overflow past PATH_LEN
    send_beat(OP_LOOKUP, 16'hABCD, 16'h1234, 32'h0, 1'b0, 1'b0);
    send_beat(OP_LOOKUP, 16'hFFFE, 16'h1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_beat(OP_LOOKUP, 16'hFFFC, 16'h3, 32'h0, 1'b0, 1'b0);
    drain();
    write_reg(CFG_MULT_START, 16'hFFFF);
    write_reg(CFG_MULT_END, 16'hFFFF);
    send_path(16'hFFFF, 16'hFFFF, 2);
    send_beat(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'h0, 1'b0, 1'b0);
    drain();

    // random phases with different hash settings
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_MULT_START, ph == 0 ? 16'd31 : 16'($urandom));
      write_reg(CFG_MULT_END, ph == 2 ? 16'd1 : 16'($urandom));
      if (ph == 1) idle_pct = 0;           // stretch without idling
      for (int it = 0; it < 20; it++) begin
        if (ph == 2 && it == 5) hold_cycles = 3000;   // fill up and stall the input
        kind = $urandom_range(9);
        k = $urandom_range(7);
        if (kind < 4) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 4);
          send_path(pool_start[k], pool_end[k], n);
        end else if (kind < 8) begin
          send_beat(OP_LOOKUP, pool_start[k], pool_end[k], $urandom,
                    1'($urandom), 1'($urandom));
        end else begin
          send_beat(1'($urandom), 16'($urandom), 16'($urandom), $urandom,
                    1'b0, 1'($urandom));  // noise
        end
      end
      idle_pct = 38;
      drain();
    end
    write_reg(CFG_MULT_START, 16'd31);
    write_reg(CFG_MULT_END, 16'd37);
    drain();

    $display("covered: %0d result beats, %0d lookup hits, several hash settings incl. extremes",
             results, hits);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
